// ----- src/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg: shared definitions of the stimulation current cross-check
// Command codes, register map, sequencer op codes and interface structs.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int LVL_W   = 16;
    localparam int TIME_W  = 32;
    localparam int RAW_W   = 21;
    localparam int TOL_W   = 7;
    localparam int RUN_W   = 4;
    localparam int PROD_W  = RAW_W + TOL_W;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [TOL_W-1:0] PCT_SCALE = 7'd100;

    localparam logic [TOL_W-1:0] TOL_RESET   = 7'd10;
    localparam logic [LVL_W-1:0] FLOOR_RESET = 16'd100;
    localparam logic [RUN_W-1:0] RUN_RESET   = 4'd3;

    localparam logic [1:0] REG_TOL   = 2'd0;
    localparam logic [1:0] REG_FLOOR = 2'd1;
    localparam logic [1:0] REG_RUN   = 2'd2;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_SESSION = 3'd1;
    localparam logic [2:0] CMD_LEVEL   = 3'd2;
    localparam logic [2:0] CMD_OBSERVE = 3'd3;
    localparam logic [2:0] CMD_QUERY   = 3'd4;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_SESSION = 3'd2;
    localparam logic [2:0] ST_LEVEL   = 3'd3;
    localparam logic [2:0] ST_BOUND   = 3'd4;
    localparam logic [2:0] ST_RUN     = 3'd5;

    localparam logic [2:0] AR_IDLE = 3'd0;
    localparam logic [2:0] AR_LOAD = 3'd1;
    localparam logic [2:0] AR_M1   = 3'd2;
    localparam logic [2:0] AR_M2   = 3'd3;
    localparam logic [2:0] AR_M3   = 3'd4;
    localparam logic [2:0] AR_M4   = 3'd5;

    typedef struct packed {
        logic [TOL_W-1:0] tol;
        logic [LVL_W-1:0] floor_ua;
        logic [RUN_W-1:0] run_needed;
    } scc_cfg_t;

    typedef struct packed {
        logic [2:0]      op;
        logic [CH_W-1:0] idx;
        logic            excess;
    } scc_store_ctl_t;

endpackage

// ----- src/scc_cfg.sv -----
// ----------------------------------------------------------------------------
// scc_cfg: configuration registers
// APB-style register file holding tolerance, floor and run length.
// ----------------------------------------------------------------------------
module scc_cfg
    import scc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output scc_cfg_t          cfg
);

    logic [TOL_W-1:0] tol_reg;
    logic [LVL_W-1:0] floor_reg;
    logic [RUN_W-1:0] run_reg;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            floor_reg <= FLOOR_RESET;
            run_reg   <= RUN_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TOL:   tol_reg   <= pwdata[TOL_W-1:0];
                REG_FLOOR: floor_reg <= pwdata[LVL_W-1:0];
                REG_RUN:   run_reg   <= pwdata[RUN_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TOL:   prdata = {{(DATA_W-TOL_W){1'b0}}, tol_reg};
            REG_FLOOR: prdata = {{(DATA_W-LVL_W){1'b0}}, floor_reg};
            REG_RUN:   prdata = {{(DATA_W-RUN_W){1'b0}}, run_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.tol        = tol_reg;
    assign cfg.floor_ua   = floor_reg;
    assign cfg.run_needed = run_reg;

endmodule

// ----- src/scc_arith.sv -----
// ----------------------------------------------------------------------------
// scc_arith: shared multiply-accumulate unit
// One 21x7 multiplier and an accumulator build the excess limit in steps.
// ----------------------------------------------------------------------------
module scc_arith
    import scc_pkg::*;
(
    input  logic              clk,
    input  logic [2:0]        op,
    input  logic [LVL_W-1:0]  bound_in,
    input  logic [RAW_W-1:0]  mag,
    input  scc_cfg_t          cfg,
    output logic              over
);

    logic [LVL_W-1:0]  bound_reg;
    logic [LVL_W-1:0]  bound_next;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] acc_next;
    logic [RAW_W-1:0]  mul_a;
    logic [TOL_W-1:0]  mul_b;
    logic [PROD_W:0]   sum;

    // limit sum stays below 2^24, so the x16 fits the accumulator
    assign sum = {1'b0, acc_reg} + {1'b0, prod_reg};

    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        bound_next = bound_reg;
        acc_next   = acc_reg;
        case (op)
            AR_LOAD:
            begin
                bound_next = bound_in;
            end
            AR_M1:
            begin
                mul_a = RAW_W'(bound_reg);
                mul_b = cfg.tol;
            end
            AR_M2:
            begin
                mul_a    = RAW_W'(cfg.floor_ua);
                mul_b    = PCT_SCALE;
                acc_next = prod_reg;
            end
            AR_M3:
            begin
                mul_a    = RAW_W'(bound_reg);
                mul_b    = PCT_SCALE;
                acc_next = (prod_reg > acc_reg) ? prod_reg : acc_reg;
            end
            AR_M4:
            begin
                mul_a    = mag;
                mul_b    = PCT_SCALE;
                acc_next = {sum[PROD_W-5:0], 4'b0000};
            end
            default: ;
        endcase
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        bound_reg <= bound_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
    end

    assign over = prod_reg > acc_reg;

endmodule

// ----- src/scc_store.sv -----
// ----------------------------------------------------------------------------
// scc_store: per-channel state
// Levels, ramp holds, excess runs and fault latches of every channel.
// ----------------------------------------------------------------------------
module scc_store
    import scc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  scc_store_ctl_t    ctl,
    input  logic [LVL_W-1:0]  level_in,
    input  logic [TIME_W-1:0] ramp,
    input  logic [TIME_W-1:0] now,
    input  logic [RUN_W-1:0]  run_needed,
    output logic [LVL_W-1:0]  bound,
    output logic              latch_sel,
    output logic              flag
);

    logic [LVL_W-1:0]  level_reg [CHANNELS];
    logic [LVL_W-1:0]  level_next[CHANNELS];
    logic [LVL_W-1:0]  held_reg  [CHANNELS];
    logic [LVL_W-1:0]  held_next [CHANNELS];
    logic [TIME_W-1:0] len_reg   [CHANNELS];
    logic [TIME_W-1:0] len_next  [CHANNELS];
    logic [TIME_W-1:0] end_reg   [CHANNELS];
    logic [TIME_W-1:0] end_next  [CHANNELS];
    logic [CHANNELS-1:0] wait_reg;
    logic [CHANNELS-1:0] wait_next;
    logic [RUN_W-1:0]  cnt_reg   [CHANNELS];
    logic [RUN_W-1:0]  cnt_next  [CHANNELS];
    logic [CHANNELS-1:0] latch_reg;
    logic [CHANNELS-1:0] latch_next;

    logic [TIME_W-1:0] anchor;
    logic [TIME_W-1:0] end_eff;
    logic              hold_live;
    logic [RUN_W-1:0]  cnt_inc;
    logic              run_hit;

    always_comb
    begin
        anchor    = now + len_reg[ctl.idx];
        end_eff   = wait_reg[ctl.idx] ? anchor : end_reg[ctl.idx];
        hold_live = (held_reg[ctl.idx] > level_reg[ctl.idx]) && (now < end_eff);
        bound     = hold_live ? held_reg[ctl.idx] : level_reg[ctl.idx];
        cnt_inc   = (cnt_reg[ctl.idx] < run_needed) ? cnt_reg[ctl.idx] + 4'd1
                                                    : cnt_reg[ctl.idx];
        run_hit   = ctl.excess && (cnt_inc >= run_needed) && !latch_reg[ctl.idx];
        flag      = (ctl.op == ST_RUN) && run_hit;
        latch_sel = latch_reg[ctl.idx];

        level_next = level_reg;
        held_next  = held_reg;
        len_next   = len_reg;
        end_next   = end_reg;
        wait_next  = wait_reg;
        cnt_next   = cnt_reg;
        latch_next = latch_reg;

        case (ctl.op)
            ST_CLEAR:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    level_next[i] = '0;
                    held_next[i]  = '0;
                    len_next[i]   = '0;
                    end_next[i]   = '0;
                    cnt_next[i]   = '0;
                end
                wait_next  = '0;
                latch_next = '0;
            end
            ST_SESSION:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    cnt_next[i] = '0;
                    if (held_reg[i] > level_reg[i])
                    begin
                        wait_next[i] = 1'b1;
                    end
                    else
                    begin
                        held_next[i] = '0;
                        wait_next[i] = 1'b0;
                    end
                end
                latch_next = '0;
            end
            ST_LEVEL:
            begin
                if ((level_in < level_reg[ctl.idx]) && (ramp != '0))
                begin
                    held_next[ctl.idx] = (held_reg[ctl.idx] > level_reg[ctl.idx])
                                       ? held_reg[ctl.idx] : level_reg[ctl.idx];
                    len_next[ctl.idx]  = ramp;
                    wait_next[ctl.idx] = 1'b1;
                end
                level_next[ctl.idx] = level_in;
            end
            ST_BOUND:
            begin
                if (wait_reg[ctl.idx])
                begin
                    end_next[ctl.idx]  = anchor;
                    wait_next[ctl.idx] = 1'b0;
                end
                if (!hold_live)
                begin
                    held_next[ctl.idx] = '0;
                end
            end
            ST_RUN:
            begin
                if (!ctl.excess)
                begin
                    cnt_next[ctl.idx] = '0;
                end
                else
                begin
                    cnt_next[ctl.idx] = cnt_inc;
                    if (run_hit)
                    begin
                        latch_next[ctl.idx] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                level_reg[i] <= '0;
                held_reg[i]  <= '0;
                len_reg[i]   <= '0;
                end_reg[i]   <= '0;
                cnt_reg[i]   <= '0;
            end
            wait_reg  <= '0;
            latch_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            held_reg  <= held_next;
            len_reg   <= len_next;
            end_reg   <= end_next;
            wait_reg  <= wait_next;
            cnt_reg   <= cnt_next;
            latch_reg <= latch_next;
        end
    end

endmodule

// ----- src/stim_current_crosscheck.sv -----
// ----------------------------------------------------------------------------
// stim_current_crosscheck: commanded versus delivered current monitor
// Command port with start/busy, one result per item, APB configuration.
//
// An item is taken at a rising edge with start high and busy low. Every
// item gives exactly one result: done is high for one cycle with
// flag_raised and latch_status valid; the receiver cannot stall it.
// An observe item on a valid channel steps through bound resolve, four passes
// through the shared 21x7 multiplier and accumulator, then compare and run
// update before its result is taken; every other item steps through a single
// execute state. busy is high from the cycle after the accept
// until the result cycle; a new item may be started in the cycle done is shown.
// Clear and session reset act on all channels at once.
// Registers (tolerance 0x0, floor 0x4, run length 0x8) must be written over
// APB only while the block is idle; the block does not enforce this. Reset
// clears all channel state and loads the register defaults.
// ----------------------------------------------------------------------------
module stim_current_crosscheck
    import scc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              command,
    input  logic [2:0]              channel,
    input  logic [LVL_W-1:0]        commanded_current,
    input  logic [TIME_W-1:0]       ramp_time_ms,
    input  logic signed [RAW_W-1:0] delivered_current,
    input  logic                    reading_invalid,
    input  logic [TIME_W-1:0]       time_now_ms,
    output logic                    done,
    output logic                    flag_raised,
    output logic                    latch_status,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_BOUND = 4'd2;
    localparam logic [3:0] S_M1    = 4'd3;
    localparam logic [3:0] S_M2    = 4'd4;
    localparam logic [3:0] S_M3    = 4'd5;
    localparam logic [3:0] S_M4    = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [2:0]        cmd_reg;
    logic [2:0]        ch_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [TIME_W-1:0] ramp_reg;
    logic [RAW_W-1:0]  mag_reg;
    logic              inv_reg;
    logic [TIME_W-1:0] now_reg;
    logic              done_reg;
    logic              done_next;
    logic              flag_reg;
    logic              flag_next;
    logic              lstat_reg;
    logic              lstat_next;

    logic              ok_in;
    logic              ok;
    logic [RAW_W-1:0]  mag_in;
    logic [2:0]        ar_op;
    scc_store_ctl_t    st_ctl;
    scc_cfg_t          cfg;
    logic [LVL_W-1:0]  bound;
    logic              latch_sel;
    logic              st_flag;
    logic              over;

    assign ok_in  = int'(channel) < CHANNELS;
    assign ok     = int'(ch_reg) < CHANNELS;
    assign mag_in = delivered_current[RAW_W-1] ? (~delivered_current + 21'd1)
                                               : delivered_current;

    scc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scc_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (st_ctl),
        .level_in   (lvl_reg),
        .ramp       (ramp_reg),
        .now        (now_reg),
        .run_needed (cfg.run_needed),
        .bound      (bound),
        .latch_sel  (latch_sel),
        .flag       (st_flag)
    );

    scc_arith u_arith (
        .clk      (clk),
        .op       (ar_op),
        .bound_in (bound),
        .mag      (mag_reg),
        .cfg      (cfg),
        .over     (over)
    );

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        flag_next     = 1'b0;
        lstat_next    = lstat_reg;
        ar_op         = AR_IDLE;
        st_ctl.op     = ST_NONE;
        st_ctl.idx    = CH_W'(ch_reg);
        st_ctl.excess = inv_reg || over;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = ((command == CMD_OBSERVE) && ok_in) ? S_BOUND : S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    CMD_CLEAR:   st_ctl.op = ST_CLEAR;
                    CMD_SESSION: st_ctl.op = ST_SESSION;
                    CMD_LEVEL:   st_ctl.op = ok ? ST_LEVEL : ST_NONE;
                    default:     st_ctl.op = ST_NONE;
                endcase
                done_next  = 1'b1;
                lstat_next = (cmd_reg == CMD_CLEAR || cmd_reg == CMD_SESSION)
                           ? 1'b0 : (ok && latch_sel);
                state_next = S_IDLE;
            end
            S_BOUND:
            begin
                st_ctl.op  = ST_BOUND;
                ar_op      = AR_LOAD;
                state_next = S_M1;
            end
            S_M1:
            begin
                ar_op      = AR_M1;
                state_next = S_M2;
            end
            S_M2:
            begin
                ar_op      = AR_M2;
                state_next = S_M3;
            end
            S_M3:
            begin
                ar_op      = AR_M3;
                state_next = S_M4;
            end
            S_M4:
            begin
                ar_op      = AR_M4;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                st_ctl.op  = ST_RUN;
                done_next  = 1'b1;
                flag_next  = st_flag;
                lstat_next = latch_sel || st_flag;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            flag_reg  <= 1'b0;
            lstat_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            flag_reg  <= flag_next;
            lstat_reg <= lstat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg  <= command;
            ch_reg   <= channel;
            lvl_reg  <= commanded_current;
            ramp_reg <= ramp_time_ms;
            mag_reg  <= mag_in;
            inv_reg  <= reading_invalid;
            now_reg  <= time_now_ms;
        end
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign flag_raised  = flag_reg;
    assign latch_status = lstat_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_flag_latch: assert property (@(posedge clk) disable iff (!rst_n)
        flag_raised |-> done && latch_status)
        else $error("flag raised without latched status");

    a_cmp_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |=> done)
        else $error("compare step gave no result");

endmodule
